### design/fisn_pkg.sv
// fast inverse square root: shared constants, types and binary32 helper functions
// used by the arithmetic units, the newton step stage and the top level

package fisn_pkg;

    localparam logic [31:0] QNAN_BITS         = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS          = 32'h7F80_0000;
    localparam logic [31:0] SIGN_BIT          = 32'h8000_0000;
    localparam logic [31:0] HALF_BITS         = 32'h3F00_0000;
    localparam logic [31:0] THREE_HALVES_BITS = 32'h3FC0_0000;
    localparam logic [31:0] MAGIC_RESET       = 32'h5F37_59DF;
    localparam logic [2:0]  STEPS_RESET       = 3'd1;
    localparam int          CFG_IDX_W         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC = 2'd0,
        REG_STEPS = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [9:0] e;
        logic [23:0]       m;
    } unp_t;

    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [11:0] e;
        logic [47:0]        p;
    } mul_a_t;

    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [11:0] e;
        logic [56:0]        s;
    } add_a_t;

    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               zero;
        logic               sign;
        logic signed [11:0] e;
        logic [30:0]        sig;
    } add_b_t;

    function automatic logic is_nan(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(logic [31:0] f);
        return f[30:0] == INF_BITS[30:0];
    endfunction

    function automatic logic is_zero(logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    // nonzero finite value: leading one at bit 23, subnormals normalized
    function automatic unp_t unpack(logic [31:0] f);
        unp_t       u;
        logic [4:0] pos;
        logic [4:0] shamt;
        pos = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (f[i])
            begin
                pos = 5'(i);
            end
        end
        shamt = 5'd23 - pos;
        if (f[30:23] == 8'd0)
        begin
            u.m = {1'b0, f[22:0]} << shamt;
            u.e = 10'sd1 - $signed({5'd0, shamt});
        end
        else
        begin
            u.m = {1'b1, f[22:0]};
            u.e = $signed({2'b00, f[30:23]});
        end
        return u;
    endfunction

    function automatic logic [63:0] shr_sticky64(logic [63:0] v, logic [9:0] n);
        logic [63:0] r;
        if (n >= 10'd64)
        begin
            r = {63'd0, |v};
        end
        else
        begin
            r = (v >> n) | {63'd0, |(v & ~({64{1'b1}} << n))};
        end
        return r;
    endfunction

    // value is sig / 2^30 * 2^(e - 127), leading one of sig at bit 30
    function automatic logic [31:0] round_pack(logic sign, logic signed [11:0] e,
                                               logic [30:0] sig);
        logic [30:0] s;
        logic [4:0]  sh;
        logic [31:0] base;
        logic [31:0] sum;
        logic [24:0] q;
        logic [31:0] r;
        s    = sig;
        base = 32'd0;
        sh   = 5'd0;
        if (e >= 12'sd255)
        begin
            r = {sign, INF_BITS[30:0]};
        end
        else
        begin
            if (e <= 12'sd0)
            begin
                if (e <= -12'sd30)
                begin
                    s = {30'd0, |sig};
                end
                else
                begin
                    sh = 5'(12'sd1 - e);
                    s  = (sig >> sh) | {30'd0, |(sig & ~({31{1'b1}} << sh))};
                end
            end
            else
            begin
                base = 32'(e - 12'sd1) << 23;
            end
            sum = {1'b0, s} + 32'h40;
            q   = sum[31:7];
            if (s[6:0] == 7'h40)
            begin
                q[0] = 1'b0;
            end
            r = {sign, 31'd0} | (base + 32'(q));
        end
        return r;
    endfunction

    function automatic mul_a_t mul_front(logic [31:0] a, logic [31:0] b);
        mul_a_t r;
        unp_t   ua;
        unp_t   ub;
        ua         = unpack(a);
        ub         = unpack(b);
        r.sign     = a[31] ^ b[31];
        r.special  = 1'b1;
        r.spec_val = {r.sign, 31'd0};
        r.p        = ua.m * ub.m;
        r.e        = 12'(ua.e) + 12'(ub.e) - 12'sd127;
        if (is_nan(a) || is_nan(b))
        begin
            r.spec_val = QNAN_BITS;
        end
        else if (is_inf(a))
        begin
            r.spec_val = is_zero(b) ? QNAN_BITS : {r.sign, INF_BITS[30:0]};
        end
        else if (is_inf(b))
        begin
            r.spec_val = is_zero(a) ? QNAN_BITS : {r.sign, INF_BITS[30:0]};
        end
        else if (!(is_zero(a) || is_zero(b)))
        begin
            r.special = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] mul_back(mul_a_t x);
        logic [31:0] r;
        if (x.special)
        begin
            r = x.spec_val;
        end
        else if (x.p[47])
        begin
            r = round_pack(x.sign, x.e + 12'sd1, {x.p[47:18], x.p[17] | (|x.p[16:0])});
        end
        else
        begin
            r = round_pack(x.sign, x.e, {x.p[46:17], x.p[16] | (|x.p[15:0])});
        end
        return r;
    endfunction

    function automatic add_a_t add_front(logic [31:0] a, logic [31:0] b);
        add_a_t      r;
        unp_t        ua;
        unp_t        ub;
        unp_t        big;
        unp_t        sml;
        logic        sa;
        logic        sb;
        logic [9:0]  d;
        logic [63:0] vb;
        ua = unpack(a);
        ub = unpack(b);
        if ((ua.e < ub.e) || ((ua.e == ub.e) && (ua.m < ub.m)))
        begin
            big = ub; sml = ua; sa = b[31]; sb = a[31];
        end
        else
        begin
            big = ua; sml = ub; sa = a[31]; sb = b[31];
        end
        d          = 10'(big.e - sml.e);
        vb         = shr_sticky64({8'd0, sml.m, 32'd0}, d);
        r.sign     = sa;
        r.e        = 12'(big.e);
        r.s        = (sa == sb) ? ({1'b0, big.m, 32'd0} + vb[56:0])
                                : ({1'b0, big.m, 32'd0} - vb[56:0]);
        r.special  = 1'b1;
        r.spec_val = 32'd0;
        if (is_nan(a) || is_nan(b))
        begin
            r.spec_val = QNAN_BITS;
        end
        else if (is_inf(a) && is_inf(b))
        begin
            r.spec_val = (a[31] ^ b[31]) ? QNAN_BITS : a;
        end
        else if (is_inf(a))
        begin
            r.spec_val = a;
        end
        else if (is_inf(b))
        begin
            r.spec_val = b;
        end
        else if (is_zero(a) && is_zero(b))
        begin
            r.spec_val = a & b;
        end
        else if (is_zero(a))
        begin
            r.spec_val = b;
        end
        else if (is_zero(b))
        begin
            r.spec_val = a;
        end
        else
        begin
            r.special = 1'b0;
        end
        return r;
    endfunction

    // leading-one search and normalization of the raw sum
    function automatic add_b_t add_norm(add_a_t x);
        add_b_t      r;
        logic [5:0]  lpos;
        logic [63:0] sh;
        lpos = 6'd0;
        for (int i = 0; i < 57; i++)
        begin
            if (x.s[i])
            begin
                lpos = 6'(i);
            end
        end
        r.special  = x.special;
        r.spec_val = x.spec_val;
        r.zero     = x.s == 57'd0;
        r.sign     = x.sign;
        r.e        = x.e + 12'(lpos) - 12'sd55;
        if (lpos > 6'd30)
        begin
            sh    = shr_sticky64({7'd0, x.s}, 10'(lpos - 6'd30));
            r.sig = sh[30:0];
        end
        else
        begin
            r.sig = x.s[30:0] << (6'd30 - lpos);
        end
        return r;
    endfunction

    function automatic logic [31:0] add_back(add_b_t x);
        logic [31:0] r;
        if (x.special)
        begin
            r = x.spec_val;
        end
        else if (x.zero)
        begin
            r = 32'd0;
        end
        else
        begin
            r = round_pack(x.sign, x.e, x.sig);
        end
        return r;
    endfunction

endpackage

### design/fisn_in_if.sv
// operand channel: valid/ready handshake carrying one binary32 operand per beat
// no dependencies

interface fisn_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_bits;

    modport source (output valid, output operand_bits, input ready);
    modport sink (input valid, input operand_bits, output ready);
endinterface

### design/fisn_out_if.sv
// result channel: valid/ready handshake carrying one binary32 result per beat
// no dependencies

interface fisn_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink (input valid, input result_bits, output ready);
endinterface

### design/fisn_mul.sv
// two-stage binary32 multiplier: unpack and 24x24 product, then normalize and round
// depends on fisn_pkg

module fisn_mul
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] z
);

    fisn_pkg::mul_a_t prod_reg;
    logic [31:0]      z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= fisn_pkg::mul_front(a, b);
            z_reg    <= fisn_pkg::mul_back(prod_reg);
        end
    end

    assign z = z_reg;

endmodule

### design/fisn_add.sv
// three-stage binary32 adder: align and add, leading-one normalize, round and pack
// depends on fisn_pkg

module fisn_add
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] z
);

    fisn_pkg::add_a_t sum_reg;
    fisn_pkg::add_b_t norm_reg;
    logic [31:0]      z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= fisn_pkg::add_front(a, b);
            norm_reg <= fisn_pkg::add_norm(sum_reg);
            z_reg    <= fisn_pkg::add_back(norm_reg);
        end
    end

    assign z = z_reg;

endmodule

### design/fisn_step.sv
// one unrolled newton step y*(1.5-((x2*y)*y)), nine stages, bypassed when inactive
// depends on fisn_pkg, fisn_mul, fisn_add

module fisn_step #(
    parameter int STEP_IDX = 0,
    parameter int STEP_W   = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       in_x2,
    input  logic [31:0]       in_y,
    input  logic [STEP_W-1:0] in_steps,
    output logic              out_valid,
    output logic [31:0]       out_x2,
    output logic [31:0]       out_y,
    output logic [STEP_W-1:0] out_steps
);

    localparam int LAT = 9;

    logic              valid_reg [1:LAT];
    logic [31:0]       x2_reg    [1:LAT];
    logic [31:0]       y_reg     [1:LAT];
    logic [STEP_W-1:0] steps_reg [1:LAT];

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] y_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[1] <= in_valid;
            for (int i = 2; i <= LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg[1]    <= in_x2;
            y_reg[1]     <= in_y;
            steps_reg[1] <= in_steps;
            for (int i = 2; i <= LAT; i++)
            begin
                x2_reg[i]    <= x2_reg[i-1];
                y_reg[i]     <= y_reg[i-1];
                steps_reg[i] <= steps_reg[i-1];
            end
        end
    end

    fisn_mul u_mul_xy (.clk(clk), .en(en), .a(in_x2), .b(in_y), .z(t1));
    fisn_mul u_mul_xyy (.clk(clk), .en(en), .a(t1), .b(y_reg[2]), .z(t2));
    fisn_add u_sub (.clk(clk), .en(en), .a(fisn_pkg::THREE_HALVES_BITS),
                    .b(t2 ^ fisn_pkg::SIGN_BIT), .z(t3));
    fisn_mul u_mul_y (.clk(clk), .en(en), .a(y_reg[7]), .b(t3), .z(y_new));

    assign out_valid = valid_reg[LAT];
    assign out_x2    = x2_reg[LAT];
    assign out_steps = steps_reg[LAT];
    assign out_y     = (steps_reg[LAT] > STEP_W'(STEP_IDX)) ? y_new : y_reg[LAT];

endmodule

### design/fast_inverse_sqrt_newton.sv
// fast inverse square root with newton refinement, binary32 in and out
// depends on fisn_pkg, fisn_in_if, fisn_out_if, fisn_mul, fisn_step

// Fully pipelined: one operand beat is accepted every cycle while no result is held
// back; each result passes the x/2 multiply, MAX_STEPS unrolled newton steps and one
// output register. Every step is always present in the pipeline; steps beyond the
// configured count pass the estimate through unchanged, so latency does not depend
// on that count. A result-side stall freezes the whole pipeline, and operand ready
// drops only while a result waits to be taken. Configuration is written by the user
// through cfg_we/cfg_index/cfg_data only while no item is in flight (not enforced).

module fast_inverse_sqrt_newton #(
    parameter int MAX_STEPS = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    fisn_in_if.sink                        operand,
    fisn_out_if.source                     result,
    input  logic                           cfg_we,
    input  logic [fisn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    logic [31:0] magic_reg;
    logic [2:0]  steps_cfg_reg;

    logic              adv;
    logic [STEP_W-1:0] steps_eff;

    logic              front_valid_reg [1:2];
    logic [31:0]       front_seed_reg  [1:2];
    logic [STEP_W-1:0] front_steps_reg [1:2];
    logic [31:0]       x2;

    logic              chain_valid [0:MAX_STEPS];
    logic [31:0]       chain_x2    [0:MAX_STEPS];
    logic [31:0]       chain_y     [0:MAX_STEPS];
    logic [STEP_W-1:0] chain_steps [0:MAX_STEPS];

    logic        out_valid_reg;
    logic [31:0] out_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= fisn_pkg::MAGIC_RESET;
            steps_cfg_reg <= fisn_pkg::STEPS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fisn_pkg::REG_MAGIC)
            begin
                magic_reg <= cfg_data;
            end
            else if (cfg_index == fisn_pkg::REG_STEPS)
            begin
                steps_cfg_reg <= cfg_data[2:0];
            end
        end
    end

    assign steps_eff = (int'(steps_cfg_reg) > MAX_STEPS) ? STEP_W'(MAX_STEPS)
                                                         : STEP_W'(steps_cfg_reg);

    // the whole pipeline moves unless a finished result is held back
    assign adv           = !out_valid_reg || result.ready;
    assign operand.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg[1] <= 1'b0;
            front_valid_reg[2] <= 1'b0;
        end
        else if (adv)
        begin
            front_valid_reg[1] <= operand.valid;
            front_valid_reg[2] <= front_valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_seed_reg[1]  <= magic_reg - {1'b0, operand.operand_bits[31:1]};
            front_seed_reg[2]  <= front_seed_reg[1];
            front_steps_reg[1] <= steps_eff;
            front_steps_reg[2] <= front_steps_reg[1];
        end
    end

    fisn_mul u_half (.clk(clk), .en(adv), .a(operand.operand_bits),
                     .b(fisn_pkg::HALF_BITS), .z(x2));

    assign chain_valid[0] = front_valid_reg[2];
    assign chain_x2[0]    = x2;
    assign chain_y[0]     = front_seed_reg[2];
    assign chain_steps[0] = front_steps_reg[2];

    for (genvar k = 0; k < MAX_STEPS; k++)
    begin : g_step
        fisn_step #(
            .STEP_IDX(k),
            .STEP_W  (STEP_W)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_valid (chain_valid[k]),
            .in_x2    (chain_x2[k]),
            .in_y     (chain_y[k]),
            .in_steps (chain_steps[k]),
            .out_valid(chain_valid[k+1]),
            .out_x2   (chain_x2[k+1]),
            .out_y    (chain_y[k+1]),
            .out_steps(chain_steps[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[MAX_STEPS];
        end
    end

    // any nan, including a nan seed with no steps, leaves as the canonical quiet nan
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_bits_reg <= fisn_pkg::is_nan(chain_y[MAX_STEPS]) ? fisn_pkg::QNAN_BITS
                                                                 : chain_y[MAX_STEPS];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_bits = out_bits_reg;

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !operand.ready)
        else $error("operand accepted while result stalled");

    a_nan_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && fisn_pkg::is_nan(result.result_bits))
            |-> (result.result_bits == fisn_pkg::QNAN_BITS))
        else $error("non-canonical nan on result");

    a_steps_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == fisn_pkg::REG_STEPS))
            |=> (steps_cfg_reg == $past(cfg_data[2:0])))
        else $error("step count write lost");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> (front_valid_reg[1] == $past(front_valid_reg[1])))
        else $error("pipeline moved during stall");

endmodule
